// ===== src/srx_pkg.sv =====
`timescale 1ns / 1ps

package srx_pkg;

  localparam int unsigned MaxHeaderBytes = 8;
  localparam int unsigned MaxFrameBytes  = 1024;
  localparam int unsigned CounterBits    = 32;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned LenBits   = 11;
  localparam int unsigned HcBits    = 4;
  localparam int unsigned OffBits   = 10;
  localparam int unsigned HdrBits   = MaxHeaderBytes * ByteBits;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned HmIdxBits = (MaxHeaderBytes > 1) ? $clog2(MaxHeaderBytes) : 1;

  typedef logic [ByteBits-1:0]    byte_t;
  typedef logic [LenBits-1:0]     len_t;
  typedef logic [HcBits-1:0]      hc_t;
  typedef logic [CounterBits-1:0] count_t;

  localparam logic [CfgIdxBits-1:0] CfgFrameMode      = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeaderCount    = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgHeaderPattern  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgFixedLength    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgLengthPosition = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgLengthOffset   = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgMaxBytes       = 3'd6;

  localparam logic [1:0] ModeLine   = 2'd0;
  localparam logic [1:0] ModeFixed  = 2'd1;
  localparam logic [1:0] ModeLenByte = 2'd2;

  localparam logic [1:0] StatusGood      = 2'd0;
  localparam logic [1:0] StatusRejected  = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  localparam byte_t CharCr      = 8'd13;
  localparam byte_t CharLf      = 8'd10;
  localparam byte_t PrintLow    = 8'd32;
  localparam byte_t PrintHigh   = 8'd127;

  localparam len_t LimitMax = len_t'(MaxFrameBytes);
  localparam hc_t  HcMax    = hc_t'(MaxHeaderBytes);

endpackage

// ===== src/serial_frame_receiver.sv =====
`timescale 1ns / 1ps

// Each result is registered in the output register. Throughput: one byte per
// cycle while the output is not stalled; while a result waits in the output
// register under stall, the input register still takes one byte and then
// stalls the input. Reset clears the frame state, the frame counters and the
// configuration to its default values; no clearing pass is needed.
module serial_frame_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              byte_present_o,
  output logic                              frame_end_o,
  output logic [1:0]                        frame_status_o,
  output logic [10:0]                       frame_length_o,
  output logic [srx_pkg::CounterBits-1:0]   good_frames_o,
  output logic [srx_pkg::CounterBits-1:0]   bad_frames_o,
  input  logic                              cfg_we_i,
  input  logic [srx_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [srx_pkg::CfgDataBits-1:0]   cfg_data_i
);

  logic [1:0]                   frame_mode_q;
  srx_pkg::hc_t                 header_count_q;
  logic [srx_pkg::HdrBits-1:0]  header_pattern_q;
  srx_pkg::len_t                fixed_length_q;
  srx_pkg::len_t                length_position_q;
  logic [srx_pkg::OffBits-1:0]  length_offset_q;
  srx_pkg::len_t                max_bytes_q;

  logic          s1_valid_q, s1_valid_d;
  srx_pkg::byte_t s1_byte_q;

  srx_pkg::len_t   byte_count_q, byte_count_d;
  srx_pkg::hc_t    header_matched_q, header_matched_d;
  logic            in_frame_q, in_frame_d;
  logic            saw_bad_q, saw_bad_d;
  srx_pkg::len_t   target_q, target_d;
  srx_pkg::count_t good_q, good_d;
  srx_pkg::count_t bad_q, bad_d;

  logic            out_valid_q, out_valid_d;
  srx_pkg::byte_t  out_byte_q;
  logic            present_q;
  logic            fend_q;
  logic [1:0]      status_q;
  srx_pkg::len_t   len_q;

  logic            res_valid;
  srx_pkg::byte_t  res_byte;
  logic            res_present;
  logic            res_fend;
  logic [1:0]      res_status;
  srx_pkg::len_t   res_len;

  logic            out_hold;
  logic            advance;
  logic            in_accept;

  srx_pkg::byte_t  b;
  srx_pkg::len_t   limit;
  srx_pkg::hc_t    hc;
  srx_pkg::hc_t    hm0;
  srx_pkg::hc_t    hm_inc;
  srx_pkg::hc_t    hm_adv;
  logic            hit;
  srx_pkg::byte_t  hdr_sel;
  srx_pkg::len_t   bc_inc;
  srx_pkg::len_t   tgt_new;
  srx_pkg::len_t   fixed_eff;
  logic            done;
  logic            restart;
  logic            over;
  logic            binary;

  assign out_hold   = out_valid_q && out_stall_i;
  assign advance    = s1_valid_q && !out_hold;
  assign in_stall_o = s1_valid_q && out_hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q      <= srx_pkg::ModeLine;
      header_count_q    <= '0;
      header_pattern_q  <= '0;
      fixed_length_q    <= srx_pkg::len_t'(1);
      length_position_q <= srx_pkg::len_t'(1);
      length_offset_q   <= '0;
      max_bytes_q       <= srx_pkg::LimitMax;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srx_pkg::CfgFrameMode:      frame_mode_q      <= cfg_data_i[1:0];
        srx_pkg::CfgHeaderCount:    header_count_q    <= cfg_data_i[srx_pkg::HcBits-1:0];
        srx_pkg::CfgHeaderPattern:  header_pattern_q  <= cfg_data_i[srx_pkg::HdrBits-1:0];
        srx_pkg::CfgFixedLength:    fixed_length_q    <= cfg_data_i[srx_pkg::LenBits-1:0];
        srx_pkg::CfgLengthPosition: length_position_q <= cfg_data_i[srx_pkg::LenBits-1:0];
        srx_pkg::CfgLengthOffset:   length_offset_q   <= cfg_data_i[srx_pkg::OffBits-1:0];
        srx_pkg::CfgMaxBytes:       max_bytes_q       <= cfg_data_i[srx_pkg::LenBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    b      = s1_byte_q;
    binary = (frame_mode_q == srx_pkg::ModeFixed) || (frame_mode_q == srx_pkg::ModeLenByte);
    limit  = ((max_bytes_q == '0) || (max_bytes_q > srx_pkg::LimitMax)) ?
             srx_pkg::LimitMax : max_bytes_q;
    hc     = (header_count_q > srx_pkg::HcMax) ? srx_pkg::HcMax : header_count_q;
    hm0    = (header_matched_q >= hc) ? '0 : header_matched_q;

    hdr_sel = header_pattern_q[hm0[srx_pkg::HmIdxBits-1:0]*srx_pkg::ByteBits +: srx_pkg::ByteBits];
    hm_inc  = hm0 + srx_pkg::hc_t'(1);
    hit     = 1'b0;
    if (b == hdr_sel) begin
      if (hm_inc >= hc) begin
        hm_adv = '0;
        hit    = 1'b1;
      end else begin
        hm_adv = hm_inc;
      end
    end else begin
      hm_adv = (b == header_pattern_q[srx_pkg::ByteBits-1:0]) ?
               srx_pkg::hc_t'(1) : '0;
    end

    bc_inc    = byte_count_q + srx_pkg::len_t'(1);
    fixed_eff = (fixed_length_q == '0) ? srx_pkg::len_t'(1) : fixed_length_q;
    tgt_new   = target_q;
    if ((frame_mode_q == srx_pkg::ModeLenByte) && (target_q == '0) &&
        (bc_inc == length_position_q)) begin
      tgt_new = srx_pkg::len_t'(b) + srx_pkg::len_t'(length_offset_q);
    end
    if (frame_mode_q == srx_pkg::ModeFixed) begin
      done = bc_inc >= fixed_eff;
    end else begin
      done = (tgt_new != '0) && (bc_inc >= tgt_new);
    end
    restart = (hc != '0) && hit;
    over    = bc_inc >= limit;

    byte_count_d     = byte_count_q;
    header_matched_d = header_matched_q;
    in_frame_d       = in_frame_q;
    saw_bad_d        = saw_bad_q;
    target_d         = target_q;
    good_d           = good_q;
    bad_d            = bad_q;
    res_valid        = 1'b0;
    res_byte         = '0;
    res_present      = 1'b0;
    res_fend         = 1'b0;
    res_status       = srx_pkg::StatusGood;
    res_len          = '0;

    if (binary) begin
      header_matched_d = hm0;
      if ((hc != '0) && !in_frame_q) begin
        header_matched_d = hm_adv;
        if (hit) begin
          in_frame_d   = 1'b1;
          byte_count_d = '0;
          target_d     = '0;
        end
      end else begin
        if (hc != '0) begin
          header_matched_d = hm_adv;
        end
        res_valid    = 1'b1;
        res_present  = 1'b1;
        res_byte     = b;
        res_len      = bc_inc;
        byte_count_d = bc_inc;
        target_d     = tgt_new;
        if (done || restart || over) begin
          res_fend     = 1'b1;
          res_status   = (done || restart) ? srx_pkg::StatusGood : srx_pkg::StatusTruncated;
          good_d       = good_q + srx_pkg::count_t'(1);
          byte_count_d = '0;
          target_d     = '0;
          in_frame_d   = restart;
        end
      end
    end else begin
      if (b == srx_pkg::CharCr) begin
        if (byte_count_q != '0) begin
          res_valid = 1'b1;
          res_fend  = 1'b1;
          res_len   = byte_count_q;
          if (saw_bad_q) begin
            res_status = srx_pkg::StatusRejected;
            bad_d      = bad_q + srx_pkg::count_t'(1);
          end else begin
            good_d = good_q + srx_pkg::count_t'(1);
          end
          byte_count_d = '0;
          saw_bad_d    = 1'b0;
        end
      end else if (b != srx_pkg::CharLf) begin
        res_valid    = 1'b1;
        res_present  = 1'b1;
        res_byte     = b;
        res_len      = bc_inc;
        byte_count_d = bc_inc;
        saw_bad_d    = saw_bad_q || (b < srx_pkg::PrintLow) || (b > srx_pkg::PrintHigh);
        if (over) begin
          res_fend     = 1'b1;
          res_status   = srx_pkg::StatusTruncated;
          good_d       = good_q + srx_pkg::count_t'(1);
          byte_count_d = '0;
          saw_bad_d    = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (advance) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      byte_count_q     <= '0;
      header_matched_q <= '0;
      in_frame_q       <= 1'b0;
      saw_bad_q        <= 1'b0;
      target_q         <= '0;
      good_q           <= '0;
      bad_q            <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        byte_count_q     <= byte_count_d;
        header_matched_q <= header_matched_d;
        in_frame_q       <= in_frame_d;
        saw_bad_q        <= saw_bad_d;
        target_q         <= target_d;
        good_q           <= good_d;
        bad_q            <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
    if (advance && res_valid) begin
      out_byte_q <= res_byte;
      present_q  <= res_present;
      fend_q     <= res_fend;
      status_q   <= res_status;
      len_q      <= res_len;
    end
  end

  logic [srx_pkg::CounterBits-1:0] good_out_q, bad_out_q;

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      good_out_q <= good_d;
      bad_out_q  <= bad_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_present_o = present_q;
  assign frame_end_o    = fend_q;
  assign frame_status_o = status_q;
  assign frame_length_o = len_q;
  assign good_frames_o  = good_out_q;
  assign bad_frames_o   = bad_out_q;

endmodule

// ===== src/srx_checker.sv =====
`timescale 1ns / 1ps

module srx_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [7:0]                        out_byte_o,
  input  logic                              byte_present_o,
  input  logic                              frame_end_o,
  input  logic [1:0]                        frame_status_o,
  input  logic [10:0]                       frame_length_o,
  input  logic [srx_pkg::CounterBits-1:0]   good_frames_o,
  input  logic [srx_pkg::CounterBits-1:0]   bad_frames_o,
  input  logic                              cfg_we_i,
  input  logic [srx_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [srx_pkg::CfgDataBits-1:0]   cfg_data_i
);

  // A stalled beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(frame_length_o) && $stable(good_frames_o) && $stable(bad_frames_o))
    else $error("stalled output beat changed");

  // Only a closing beat carries a nonzero status.
  a_status_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> frame_status_o == srx_pkg::StatusGood)
    else $error("open frame beat carries a status");

  // A beat without a payload byte is a line close with a zero byte.
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> frame_end_o && out_byte_o == '0)
    else $error("empty beat is not a frame close");

  // Every result belongs to a frame of at least one byte.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o != '0)
    else $error("result with zero frame length");

endmodule

bind serial_frame_receiver srx_checker u_srx_checker (.*);

// ===== tb/sv/serial_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module serial_frame_receiver_tb;
  import srx_pkg::*;

  localparam int          ClkPeriod  = 10;
  localparam int          ResetCycles = 7;
  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 300;
  localparam int          LongLine   = 110;
  localparam int          LongLimit  = 100;
  localparam int          PhaseBeats = 65;
  localparam logic [1:0]  ModeSpare  = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    hc_t                hdr_count;
    logic [HdrBits-1:0] hdr_pattern;
    len_t               fix_len;
    len_t               len_pos;
    logic [OffBits-1:0] len_off;
    len_t               max_len;
  } framer_cfg_t;

  typedef struct packed {
    byte_t      data;
    logic       present;
    logic       last;
    logic [1:0] status;
    len_t       length;
    count_t     good;
    count_t     bad;
  } frame_beat_t;

  class frame_cut_checker;
    framer_cfg_t   cfg;
    len_t          byte_cnt;
    hc_t           hdr_hits;
    bit            in_frame;
    bit            bad_seen;
    len_t          target;
    count_t        good_cnt;
    count_t        bad_cnt;
    frame_beat_t   expected_beats[$];
    int unsigned   mismatches;

    function new();
      cfg.mode        = ModeLine;
      cfg.hdr_count   = '0;
      cfg.hdr_pattern = '0;
      cfg.fix_len     = len_t'(1);
      cfg.len_pos     = len_t'(1);
      cfg.len_off     = '0;
      cfg.max_len     = LimitMax;
      byte_cnt        = '0;
      hdr_hits        = '0;
      in_frame        = 1'b0;
      bad_seen        = 1'b0;
      target          = '0;
      good_cnt        = '0;
      bad_cnt         = '0;
      mismatches      = 0;
    endfunction

    function bit advance_header_match(byte_t b, hc_t hc);
      if (b == cfg.hdr_pattern[8*int'(hdr_hits[2:0]) +: 8]) begin
        hdr_hits = hdr_hits + hc_t'(1);
        if (hdr_hits >= hc) begin
          hdr_hits = '0;
          return 1'b1;
        end
      end else begin
        hdr_hits = (b == cfg.hdr_pattern[7:0]) ? hc_t'(1) : hc_t'(0);
      end
      return 1'b0;
    endfunction

    function void predict_rx_byte(byte_t b);
      frame_beat_t r;
      len_t        limit;
      hc_t         hc;
      bit          done;
      bit          restart;
      r = '0;
      limit = (cfg.max_len == '0 || cfg.max_len > LimitMax) ? LimitMax : cfg.max_len;
      if (cfg.mode == ModeFixed || cfg.mode == ModeLenByte) begin
        hc = (cfg.hdr_count > HcMax) ? HcMax : cfg.hdr_count;
        restart = 1'b0;
        if (hdr_hits >= hc) hdr_hits = '0;
        if (hc != '0 && !in_frame) begin
          if (advance_header_match(b, hc)) begin
            in_frame = 1'b1;
            byte_cnt = '0;
            target   = '0;
          end
          return;
        end
        byte_cnt  = byte_cnt + len_t'(1);
        r.present = 1'b1;
        r.data    = b;
        r.length  = byte_cnt;
        if (cfg.mode == ModeLenByte && target == '0 && byte_cnt == cfg.len_pos) begin
          target = len_t'(b) + len_t'(cfg.len_off);
        end
        if (cfg.mode == ModeFixed) begin
          done = byte_cnt >= ((cfg.fix_len == '0) ? len_t'(1) : cfg.fix_len);
        end else begin
          done = target != '0 && byte_cnt >= target;
        end
        if (hc != '0) restart = advance_header_match(b, hc);
        if (done || restart) begin
          r.last = 1'b1;
        end else if (byte_cnt >= limit) begin
          r.last   = 1'b1;
          r.status = StatusTruncated;
        end
        if (r.last) begin
          good_cnt = good_cnt + count_t'(1);
          byte_cnt = '0;
          target   = '0;
          in_frame = restart;
        end
      end else begin
        if (b == CharCr) begin
          if (byte_cnt == '0) return;
          r.last   = 1'b1;
          r.length = byte_cnt;
          if (bad_seen) begin
            r.status = StatusRejected;
            bad_cnt  = bad_cnt + count_t'(1);
          end else begin
            good_cnt = good_cnt + count_t'(1);
          end
          byte_cnt = '0;
          bad_seen = 1'b0;
        end else if (b == CharLf) begin
          return;
        end else begin
          byte_cnt = byte_cnt + len_t'(1);
          if (b < PrintLow || b > PrintHigh) bad_seen = 1'b1;
          r.present = 1'b1;
          r.data    = b;
          r.length  = byte_cnt;
          if (byte_cnt >= limit) begin
            r.last   = 1'b1;
            r.status = StatusTruncated;
            good_cnt = good_cnt + count_t'(1);
            byte_cnt = '0;
            bad_seen = 1'b0;
          end
        end
      end
      r.good = good_cnt;
      r.bad  = bad_cnt;
      expected_beats = {expected_beats, r};
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame_beat(frame_beat_t got);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with no expected result waiting");
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("byte_present", want.present, got.present);
      compare_field("frame_end", want.last, got.last);
      compare_field("frame_status", want.status, got.status);
      compare_field("frame_length", want.length, got.length);
      compare_field("good_frames", want.good, got.good);
      compare_field("bad_frames", want.bad, got.bad);
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  byte_t                  rx_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  byte_t                  out_byte_o;
  logic                   byte_present_o;
  logic                   frame_end_o;
  logic [1:0]             frame_status_o;
  len_t                   frame_length_o;
  count_t                 good_frames_o;
  count_t                 bad_frames_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  frame_cut_checker frames;
  framer_cfg_t      cur_cfg;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  bit               hold_req  = 1'b0;
  int               hold_left = 0;
  int               cycles    = 0;

  serial_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_present_o(byte_present_o),
    .frame_end_o   (frame_end_o),
    .frame_status_o(frame_status_o),
    .frame_length_o(frame_length_o),
    .good_frames_o (good_frames_o),
    .bad_frames_o  (bad_frames_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    frame_beat_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) frames.predict_rx_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.data    = out_byte_o;
        got.present = byte_present_o;
        got.last    = frame_end_o;
        got.status  = frame_status_o;
        got.length  = frame_length_o;
        got.good    = good_frames_o;
        got.bad     = bad_frames_o;
        frames.check_frame_beat(got);
      end
    end
  end

  // The long hold-off is counted here so the sender keeps offering meanwhile.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_queue(byte_t seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Bytes that end in a hunt, an LF or an empty line leave nothing to wait for,
  // so the task keeps waiting past the last expected result as well.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames.expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(framer_cfg_t c);
    drain_results();
    write_reg(CfgFrameMode,      CfgDataBits'(c.mode));
    write_reg(CfgHeaderCount,    CfgDataBits'(c.hdr_count));
    write_reg(CfgHeaderPattern,  c.hdr_pattern);
    write_reg(CfgFixedLength,    CfgDataBits'(c.fix_len));
    write_reg(CfgLengthPosition, CfgDataBits'(c.len_pos));
    write_reg(CfgLengthOffset,   CfgDataBits'(c.len_off));
    write_reg(CfgMaxBytes,       CfgDataBits'(c.max_len));
    cfg_we_i   <= 1'b0;
    cur_cfg    = c;
    frames.cfg = c;
  endtask

  function automatic framer_cfg_t phase_config(int p);
    framer_cfg_t c;
    c.mode        = ModeLine;
    c.hdr_count   = hc_t'($urandom_range(1, 3));
    c.hdr_pattern = {$urandom, $urandom};
    c.fix_len     = len_t'($urandom_range(0, 10));
    c.len_pos     = len_t'($urandom_range(1, 4));
    c.len_off     = OffBits'($urandom_range(0, 4));
    c.max_len     = ($urandom_range(1) == 0) ? '0 : len_t'($urandom_range(1, 40));
    case (p)
      0: c.max_len = len_t'($urandom_range(1, 30));
      1: begin
        c.mode    = ModeFixed;
        c.max_len = '0;
      end
      2: begin
        c.mode      = ModeLenByte;
        c.hdr_count = hc_t'(2);
        c.max_len   = LimitMax;
      end
      3: begin
        c.mode    = ModeSpare;
        c.max_len = len_t'(1);
      end
      4: begin
        c.mode      = ModeFixed;
        c.hdr_count = '0;
      end
      5: begin
        c.mode        = ModeLenByte;
        c.hdr_count   = HcMax;
        c.hdr_pattern = '1;
        c.len_pos     = LimitMax;
        c.len_off     = '1;
        c.max_len     = len_t'(20);
      end
      6: begin
        c.mode        = ModeFixed;
        c.hdr_count   = '1;
        c.hdr_pattern = '0;
        c.fix_len     = '1;
        c.max_len     = len_t'(12);
      end
      7: begin
        c.mode      = ModeLenByte;
        c.hdr_count = hc_t'(1);
        c.len_pos   = '0;
        c.max_len   = '1;
      end
      8: c.max_len = '0;
      9: begin
        c.mode      = ModeFixed;
        c.hdr_count = hc_t'(12);
        c.fix_len   = LimitMax;
      end
      10: begin
        c.mode      = ModeLenByte;
        c.hdr_count = '0;
        c.len_off   = '0;
      end
      default: begin
        c.mode      = ModeLenByte;
        c.hdr_count = hc_t'(3);
        c.len_off   = '1;
      end
    endcase
    return c;
  endfunction

  // Mostly well-formed lines or frames, led by the header if one is set, with random content, some noise.
  task automatic send_stream(int n);
    int    sent;
    int    hc;
    int    plen;
    int    tgt;
    int    lb;
    int    pos;
    byte_t b;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        send_byte(byte_t'($urandom));
        sent++;
      end else if (cur_cfg.mode != ModeFixed && cur_cfg.mode != ModeLenByte) begin
        plen = $urandom_range(12);
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(99) < 6) begin
            b = byte_t'($urandom);
          end else if ($urandom_range(99) < 3) begin
            b = CharLf;
          end else begin
            b = byte_t'($urandom_range(PrintLow, PrintHigh));
          end
          send_byte(b);
        end
        send_byte(CharCr);
        sent += plen + 1;
      end else begin
        hc = int'((cur_cfg.hdr_count > HcMax) ? HcMax : cur_cfg.hdr_count);
        for (int i = 0; i < hc; i++) send_byte(cur_cfg.hdr_pattern[8*i +: 8]);
        pos = int'(cur_cfg.len_pos);
        tgt = 0;
        if (cur_cfg.mode == ModeFixed) begin
          plen = (cur_cfg.fix_len == '0) ? 1 : int'(cur_cfg.fix_len);
        end else begin
          if (pos >= 1 && pos <= 30) tgt = $urandom_range(pos, pos + 8);
          else tgt = $urandom_range(1, 12);
          plen = tgt;
        end
        if (plen > 40) plen = $urandom_range(1, 40);
        for (int i = 1; i <= plen; i++) begin
          b = byte_t'($urandom);
          if (cur_cfg.mode == ModeLenByte && i == pos) begin
            lb = tgt - int'(cur_cfg.len_off);
            if (lb >= 0 && lb <= 255) b = byte_t'(lb);
          end
          send_byte(b);
        end
        sent += hc + plen;
      end
    end
  endtask

  initial begin
    framer_cfg_t c;
    byte_t       dir_bytes[$];
    frames  = new();
    cur_cfg = frames.cfg;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_bytes = '{8'd72, PrintLow, PrintHigh, CharCr, CharLf, CharCr, 8'd0, 8'd255, CharCr};
    send_queue(dir_bytes);

    c         = cur_cfg;
    c.mode    = ModeSpare;
    c.max_len = len_t'(2);
    apply_config(c);
    dir_bytes = '{8'd97, 8'd98, 8'd1, 8'd2};
    send_queue(dir_bytes);

    c             = cur_cfg;
    c.mode        = ModeFixed;
    c.hdr_count   = hc_t'(2);
    c.hdr_pattern = HdrBits'(16'h5aa5);
    c.fix_len     = '0;
    c.max_len     = '0;
    apply_config(c);
    dir_bytes = '{8'ha5, 8'ha5, 8'h5a, 8'h33};
    send_queue(dir_bytes);

    c         = cur_cfg;
    c.mode    = ModeLenByte;
    c.len_pos = len_t'(1);
    c.len_off = '0;
    c.max_len = LimitMax;
    apply_config(c);
    dir_bytes = '{8'ha5, 8'h5a, 8'h02, 8'hee, 8'ha5, 8'h5a, 8'h00, 8'ha5, 8'h5a,
                  8'h03, 8'ha5, 8'h5a};
    send_queue(dir_bytes);

    for (int p = 0; p < 12; p++) begin
      apply_config(phase_config(p));
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 48;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 48;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      send_stream(PhaseBeats);
    end

    // One long line runs into the frame limit while the receiver holds off.
    c         = cur_cfg;
    c.mode    = ModeLine;
    c.max_len = len_t'(LongLimit);
    apply_config(c);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < LongLine; i++) begin
      send_byte(byte_t'($urandom_range(PrintLow, PrintHigh)));
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (frames.mismatches == 0 && frames.expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/srx_pkg.sv
src/serial_frame_receiver.sv
src/srx_checker.sv
tb/sv/serial_frame_receiver_tb.sv
